// File: src/spfa_pkg.sv
// ----------------------------------------------------------------------------
// SPFA package
// Shared types and constants of the shortest-path search block.
// ----------------------------------------------------------------------------
package spfa_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int WEIGHT_BITS_DEF  = 16;

    localparam int VTX_W    = 6;
    localparam int WIN_W    = 16;
    localparam int DIST_W   = 22;
    localparam int CFG_W    = 7;
    localparam int OP_W     = 2;

    localparam int DIST_CAP   = 32676;
    localparam int DIST_FLOOR = -2097152;
    localparam logic [CFG_W-1:0] VCOUNT_RESET = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_WRITE = 2'd1,
        OP_RUN   = 2'd2,
        OP_NONE  = 2'd3
    } spfa_op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT,
        ST_POP,
        ST_LOADU,
        ST_GETU,
        ST_RD,
        ST_EVAL,
        ST_ORD,
        ST_OLD,
        ST_OWT
    } spfa_state_t;

endpackage

// File: src/spfa_shortest_paths.sv
// ----------------------------------------------------------------------------
// SPFA shortest paths
// Adjacency matrix of weighted directed edges with a queue-based
// Bellman-Ford search over it, run by a small sequencer.
// ----------------------------------------------------------------------------
// Usage: items enter on s_valid/s_ready. A clear item sweeps the edge memory
// one entry per cycle and returns nothing. A write item stores or removes
// one edge, so writes can stream back to back. A run item searches from
// s_from_vertex and then delivers one result item per vertex in use on
// m_valid/m_ready, or a single item flagged negative_cycle; m_last marks
// the final result of a run. For each dequeued vertex a run steps through
// the matrix entries of its row, each with one edge-memory read and one
// relax step through the shared adder and comparator, then it passes each
// result item through a read, a load and a wait state. The input is not
// ready while a run or clear is in progress.
// After reset the block sweeps and clears the whole edge memory before it
// takes its first item; vertex_count returns to 64 and may be written on
// cfg_wr_en at any time the block is idle. A stalled receiver simply holds
// the sequencer on the current result item; nothing is lost.
// ----------------------------------------------------------------------------
module spfa_shortest_paths
    import spfa_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_W-1:0]         cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [OP_W-1:0]          s_op,
    input  logic [VTX_W-1:0]         s_from_vertex,
    input  logic [VTX_W-1:0]         s_to_vertex,
    input  logic signed [WIN_W-1:0]  s_edge_weight,
    input  logic                     s_edge_present,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [VTX_W-1:0]         m_vertex,
    output logic signed [DIST_W-1:0] m_distance,
    output logic [VTX_W-1:0]         m_predecessor,
    output logic                     m_negative_cycle,
    output logic                     m_last
);

    localparam int VW     = $clog2(MAX_VERTICES);
    localparam int EAW    = 2 * VW;
    localparam int EDEPTH = 1 << EAW;
    localparam int SUM_W  = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;
    localparam logic [CFG_W-1:0] N_MAX = CFG_W'(MAX_VERTICES);
    localparam logic signed [DIST_W-1:0] CAP_D   = DIST_W'(DIST_CAP);
    localparam logic signed [DIST_W-1:0] FLOOR_D = DIST_W'(DIST_FLOOR);
    localparam logic signed [SUM_W-1:0]  FLOOR_S = SUM_W'(DIST_FLOOR);

    // Memories
    logic [WEIGHT_BITS:0]     edge_mem [EDEPTH];
    logic [DIST_W-1:0]        dist_mem [MAX_VERTICES];
    logic [VW-1:0]            pred_mem [MAX_VERTICES];
    logic [CFG_W-1:0]         cnt_mem  [MAX_VERTICES];
    logic [VW-1:0]            fifo_mem [MAX_VERTICES];

    logic [WEIGHT_BITS:0]     edge_rdata_reg;
    logic signed [DIST_W-1:0] dist_rdata_reg;
    logic [VW-1:0]            pred_rdata_reg;
    logic [CFG_W-1:0]         cnt_rdata_reg;
    logic [VW-1:0]            fifo_rdata_reg;

    logic                     edge_we;
    logic [EAW-1:0]           edge_waddr;
    logic [WEIGHT_BITS:0]     edge_wdata;
    logic                     dist_we;
    logic [VW-1:0]            dist_waddr;
    logic [DIST_W-1:0]        dist_wdata;
    logic [VW-1:0]            dist_raddr;
    logic [VW-1:0]            pred_wdata;
    logic                     cnt_we;
    logic [VW-1:0]            cnt_waddr;
    logic [CFG_W-1:0]         cnt_wdata;
    logic                     fifo_we;
    logic [VW-1:0]            fifo_waddr;

    // Control and datapath registers
    spfa_state_t              state_reg, state_next;
    logic [EAW-1:0]           sweep_reg, sweep_next;
    logic [CFG_W-1:0]         vcount_reg;
    logic [CFG_W-1:0]         n_reg, n_next;
    logic [VW-1:0]            src_reg, src_next;
    logic [VW-1:0]            u_reg, u_next;
    logic [VW-1:0]            v_reg, v_next;
    logic signed [DIST_W-1:0] du_reg, du_next;
    logic [MAX_VERTICES-1:0]  touched_reg, touched_next;
    logic [MAX_VERTICES-1:0]  queued_reg, queued_next;
    logic [MAX_VERTICES-1:0]  cntv_reg, cntv_next;
    logic [VW-1:0]            head_reg, head_next;
    logic [VW:0]              count_reg, count_next;
    logic                     m_valid_reg, m_valid_next;
    logic [VTX_W-1:0]         m_vertex_reg, m_vertex_next;
    logic signed [DIST_W-1:0] m_distance_reg, m_distance_next;
    logic [VTX_W-1:0]         m_pred_reg, m_pred_next;
    logic                     m_neg_reg, m_neg_next;
    logic                     m_last_reg, m_last_next;

    // Relax datapath
    logic                     accept;
    logic [CFG_W-1:0]         n_clamped;
    logic signed [WEIGHT_BITS-1:0] w_in;
    logic signed [WEIGHT_BITS-1:0] w_e;
    logic signed [DIST_W-1:0] dv;
    logic signed [SUM_W-1:0]  sum;
    logic signed [DIST_W-1:0] sat;
    logic                     take;
    logic [CFG_W-1:0]         new_cnt;
    logic [VW:0]              tail_sum;
    logic [VW-1:0]            tail;
    logic                     v_is_last;

    assign accept    = s_valid && s_ready;
    assign w_in      = WEIGHT_BITS'(s_edge_weight);
    assign w_e       = edge_rdata_reg[WEIGHT_BITS-1:0];
    assign dv        = touched_reg[v_reg] ? dist_rdata_reg : CAP_D;
    assign sum       = SUM_W'(du_reg) + SUM_W'(w_e);
    assign sat       = (sum < FLOOR_S) ? FLOOR_D : sum[DIST_W-1:0];
    assign take      = edge_rdata_reg[WEIGHT_BITS] && (sat < dv);
    assign new_cnt   = (cntv_reg[v_reg] ? cnt_rdata_reg : '0) + CFG_W'(1);
    assign tail_sum  = (VW+1)'(head_reg) + count_reg;
    assign tail      = (tail_sum >= (VW+1)'(MAX_VERTICES))
                       ? VW'(tail_sum - (VW+1)'(MAX_VERTICES)) : tail_sum[VW-1:0];
    assign v_is_last = (CFG_W'(v_reg) + CFG_W'(1)) == n_reg;

    always_comb begin
        if (vcount_reg == '0) begin
            n_clamped = CFG_W'(1);
        end else if (vcount_reg > N_MAX) begin
            n_clamped = N_MAX;
        end else begin
            n_clamped = vcount_reg;
        end
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_vertex         = m_vertex_reg;
    assign m_distance       = m_distance_reg;
    assign m_predecessor    = m_pred_reg;
    assign m_negative_cycle = m_neg_reg;
    assign m_last           = m_last_reg;

    always_comb begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        n_next          = n_reg;
        src_next        = src_reg;
        u_next          = u_reg;
        v_next          = v_reg;
        du_next         = du_reg;
        touched_next    = touched_reg;
        queued_next     = queued_reg;
        cntv_next       = cntv_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        m_valid_next    = m_valid_reg;
        m_vertex_next   = m_vertex_reg;
        m_distance_next = m_distance_reg;
        m_pred_next     = m_pred_reg;
        m_neg_next      = m_neg_reg;
        m_last_next     = m_last_reg;

        edge_we    = 1'b0;
        edge_waddr = sweep_reg;
        edge_wdata = '0;
        dist_we    = 1'b0;
        dist_waddr = v_reg;
        dist_wdata = sat;
        dist_raddr = v_reg;
        pred_wdata = u_reg;
        cnt_we     = 1'b0;
        cnt_waddr  = v_reg;
        cnt_wdata  = new_cnt;
        fifo_we    = 1'b0;
        fifo_waddr = tail;

        unique case (state_reg)
            ST_CLEAR: begin
                edge_we    = 1'b1;
                sweep_next = sweep_reg + EAW'(1);
                if (sweep_reg == EAW'(EDEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    priority case (spfa_op_t'(s_op))
                        OP_CLEAR: begin
                            sweep_next = '0;
                            state_next = ST_CLEAR;
                        end
                        OP_WRITE: begin
                            if ((CFG_W'(s_from_vertex) < N_MAX)
                                    && (CFG_W'(s_to_vertex) < N_MAX)) begin
                                edge_we    = 1'b1;
                                edge_waddr = {s_from_vertex[VW-1:0],
                                              s_to_vertex[VW-1:0]};
                                edge_wdata = {s_edge_present, w_in};
                            end
                        end
                        OP_RUN: begin
                            n_next       = n_clamped;
                            src_next     = s_from_vertex[VW-1:0];
                            touched_next = '0;
                            queued_next  = '0;
                            cntv_next    = '0;
                            head_next    = '0;
                            count_next   = '0;
                            v_next       = '0;
                            // A source outside the graph skips the search and
                            // reports every vertex as unreachable.
                            if (CFG_W'(s_from_vertex) >= n_clamped) begin
                                state_next = ST_ORD;
                            end else begin
                                state_next = ST_INIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_INIT: begin
                dist_we    = 1'b1;
                dist_waddr = src_reg;
                dist_wdata = '0;
                pred_wdata = src_reg;
                cnt_we     = 1'b1;
                cnt_waddr  = src_reg;
                cnt_wdata  = CFG_W'(1);
                fifo_we    = 1'b1;
                fifo_waddr = '0;
                touched_next[src_reg] = 1'b1;
                queued_next[src_reg]  = 1'b1;
                cntv_next[src_reg]    = 1'b1;
                count_next = (VW+1)'(1);
                state_next = ST_POP;
            end
            ST_POP: begin
                if (count_reg == '0) begin
                    v_next     = '0;
                    state_next = ST_ORD;
                end else begin
                    head_next  = (head_reg == VW'(MAX_VERTICES - 1))
                                 ? '0 : head_reg + VW'(1);
                    count_next = count_reg - (VW+1)'(1);
                    state_next = ST_LOADU;
                end
            end
            ST_LOADU: begin
                u_next     = fifo_rdata_reg;
                dist_raddr = fifo_rdata_reg;
                queued_next[fifo_rdata_reg] = 1'b0;
                state_next = ST_GETU;
            end
            ST_GETU: begin
                du_next    = touched_reg[u_reg] ? dist_rdata_reg : CAP_D;
                v_next     = '0;
                state_next = ST_RD;
            end
            ST_RD: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                state_next = ST_RD;
                if (v_is_last) begin
                    state_next = ST_POP;
                end else begin
                    v_next = v_reg + VW'(1);
                end
                if (take) begin
                    dist_we = 1'b1;
                    touched_next[v_reg] = 1'b1;
                    // A self loop lowers the distance of the row vertex too.
                    if (v_reg == u_reg) begin
                        du_next = sat;
                    end
                    if (!queued_reg[v_reg]) begin
                        fifo_we    = 1'b1;
                        count_next = count_reg + (VW+1)'(1);
                        if (new_cnt >= n_reg) begin
                            m_valid_next    = 1'b1;
                            m_vertex_next   = VTX_W'(v_reg);
                            m_distance_next = '0;
                            m_pred_next     = '0;
                            m_neg_next      = 1'b1;
                            m_last_next     = 1'b1;
                            state_next      = ST_OWT;
                        end else begin
                            cnt_we = 1'b1;
                            cntv_next[v_reg]   = 1'b1;
                            queued_next[v_reg] = 1'b1;
                        end
                    end
                end
            end
            ST_ORD: begin
                state_next = ST_OLD;
            end
            ST_OLD: begin
                m_valid_next    = 1'b1;
                m_vertex_next   = VTX_W'(v_reg);
                m_distance_next = touched_reg[v_reg] ? dist_rdata_reg : CAP_D;
                m_pred_next     = VTX_W'(touched_reg[v_reg] ? pred_rdata_reg : src_reg);
                m_neg_next      = 1'b0;
                m_last_next     = v_is_last;
                state_next      = ST_OWT;
            end
            ST_OWT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        v_next     = v_reg + VW'(1);
                        state_next = ST_ORD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            sweep_reg   <= '0;
            vcount_reg  <= VCOUNT_RESET;
            touched_reg <= '0;
            queued_reg  <= '0;
            cntv_reg    <= '0;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            n_reg       <= VCOUNT_RESET;
        end else begin
            state_reg   <= state_next;
            sweep_reg   <= sweep_next;
            if (cfg_wr_en) begin
                vcount_reg <= cfg_wr_data;
            end
            touched_reg <= touched_next;
            queued_reg  <= queued_next;
            cntv_reg    <= cntv_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            n_reg       <= n_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg        <= src_next;
        u_reg          <= u_next;
        v_reg          <= v_next;
        du_reg         <= du_next;
        m_vertex_reg   <= m_vertex_next;
        m_distance_reg <= m_distance_next;
        m_pred_reg     <= m_pred_next;
        m_neg_reg      <= m_neg_next;
        m_last_reg     <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (edge_we) begin
            edge_mem[edge_waddr] <= edge_wdata;
        end
        edge_rdata_reg <= edge_mem[{u_reg, v_reg}];
    end

    always_ff @(posedge aclk) begin
        if (dist_we) begin
            dist_mem[dist_waddr] <= dist_wdata;
            pred_mem[dist_waddr] <= pred_wdata;
        end
        dist_rdata_reg <= dist_mem[dist_raddr];
        pred_rdata_reg <= pred_mem[v_reg];
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rdata_reg <= cnt_mem[v_reg];
    end

    always_ff @(posedge aclk) begin
        if (fifo_we) begin
            fifo_mem[fifo_waddr] <= (state_reg == ST_INIT) ? src_reg : v_reg;
        end
        fifo_rdata_reg <= fifo_mem[head_reg];
    end

    // The queue never holds more entries than there are vertices in use.
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POP) |-> (CFG_W'(count_reg) <= n_reg))
        else $error("queue holds more entries than vertices in use");

    // A negative-cycle item is always the final item of its run.
    a_neg_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_negative_cycle) |-> m_last)
        else $error("negative-cycle item without last");

    // The relax step only visits columns inside the graph.
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL) |-> (CFG_W'(v_reg) < n_reg))
        else $error("relax step beyond vertex count");

    // No new item is taken while a result item waits.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while a result is pending");

    // Once a run reaches the queue, its source is marked reached.
    a_src_touched: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(state_reg) == ST_INIT) |-> touched_reg[src_reg])
        else $error("source not marked after run start");

endmodule
